>>> rtl/core/constant_power_pan_gains_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the constant-power pan gain core
// Shared concurrent-check forms, clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CONSTANT_POWER_PAN_GAINS_CORE_MACROS_SVH
`define CONSTANT_POWER_PAN_GAINS_CORE_MACROS_SVH

// same-cycle implication
`define CPPG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cppg check failed");

// next-cycle implication
`define CPPG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cppg check failed");

`endif

>>> rtl/core/cppg_pkg.sv
// ----------------------------------------------------------------------------
// cppg_pkg
// Shared constants and elaboration-time helpers for the pan gain core.
// ----------------------------------------------------------------------------
package cppg_pkg;

   localparam int unsigned Q32_W = 32;

   // floor square root, elaboration time only
   function automatic longint unsigned isqrt64(input longint unsigned v_arg);
      longint unsigned v;
      longint unsigned r;
      longint unsigned b;
      v = v_arg;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(-1/2^k) in Q0.32 by repeated square roots of one half
   function automatic logic [31:0] root_const(input int k);
      longint unsigned c;
      c = 64'd1 << 31;
      for (int n = 0; n < k; n++) c = isqrt64(c << 32);
      return c[31:0];
   endfunction

endpackage

>>> rtl/core/cppg_front.sv
// ----------------------------------------------------------------------------
// cppg_front
// Input register: takes a pan position and turns it into exponent distance
// and a side flag.
// ----------------------------------------------------------------------------
module cppg_front #(
   parameter int FRACTION_BITS = 15
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [FRACTION_BITS:0]   req_pan_position,
   output logic                     item_valid,
   input  logic                     item_ready,
   output logic [FRACTION_BITS:0]   item_dist,
   output logic                     item_swap
);
   import cppg_pkg::*;

   localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

   logic                   valid_ff, valid_in;
   logic [FRACTION_BITS:0] dist_ff, dist_in;
   logic                   swap_ff, swap_in;
   logic                   take;
   logic                   neg;

   assign req_full = valid_ff && !item_ready;
   assign take     = req_push && !req_full;
   assign neg      = req_pan_position[FRACTION_BITS];

   always_comb begin
      valid_in = take || (valid_ff && !item_ready);
      // right leans near only for a strictly positive pan
      swap_in  = !neg && (req_pan_position != '0);
      dist_in  = neg ? (req_pan_position + ONE) : (ONE - req_pan_position);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         dist_ff <= dist_in;
         swap_ff <= swap_in;
      end
   end

   assign item_valid = valid_ff;
   assign item_dist  = dist_ff;
   assign item_swap  = swap_ff;

endmodule

>>> rtl/core/cppg_queue.sv
// ----------------------------------------------------------------------------
// cppg_queue
// Two-entry queue between the front register and the gain pipeline.
// ----------------------------------------------------------------------------
module cppg_queue #(
   parameter int WIDTH = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_take,
   output logic [WIDTH-1:0] rd_data
);
   import cppg_pkg::*;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_wr, do_rd;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_take && rd_valid;
   assign rd_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

>>> rtl/core/cppg_back.sv
// ----------------------------------------------------------------------------
// cppg_back
// Gain pipeline: exp2 by a chain of root factors, square, digit-serial
// square root, then rounding to Q1.F in the output register.
// ----------------------------------------------------------------------------
module cppg_back #(
   parameter int FRACTION_BITS = 15
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   output logic                     item_take,
   input  logic [FRACTION_BITS:0]   item_dist,
   input  logic                     item_swap,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [FRACTION_BITS:0]   rsp_left_gain,
   output logic [FRACTION_BITS:0]   rsp_right_gain
);
   import cppg_pkg::*;

   localparam int F      = FRACTION_BITS;
   localparam int NEXP   = F + 1;
   localparam int NSQRT  = 32;
   localparam int REM_W  = 34;
   localparam logic [32:0] Q_ONE = 33'h1_0000_0000;

   logic adv;

   // exponent chain
   logic [32:0] e_acc_ff   [NEXP+1];
   logic [F:0]  e_dist_ff  [NEXP+1];
   logic        e_swap_ff  [NEXP+1];
   logic        e_valid_ff [NEXP+1];

   // square root stages; stage 0 is loaded by the squaring step
   logic [REM_W-1:0] s_rem_ff   [NSQRT+1];
   logic [31:0]      s_root_ff  [NSQRT+1];
   logic [31:0]      s_rad_ff   [NSQRT+1];
   logic [32:0]      s_near_ff  [NSQRT+1];
   logic             s_swap_ff  [NSQRT+1];
   logic             s_valid_ff [NSQRT+1];

   logic             out_valid_ff;
   logic [F:0]       out_left_ff, out_right_ff, out_left_in, out_right_in;

   assign adv       = !out_valid_ff || rsp_pop;
   assign item_take = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         e_valid_ff[0] <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_acc_ff[0]  <= Q_ONE;
         e_dist_ff[0] <= item_dist;
         e_swap_ff[0] <= item_swap;
      end
   end

   for (genvar j = 0; j < NEXP; j++) begin : g_exp
      localparam logic [31:0] C = root_const(j + 1);
      logic [63:0] prod;
      logic [32:0] acc_in;

      always_comb begin
         prod = 64'(e_acc_ff[j][31:0]) * 64'(C) + 64'h8000_0000;
         if (!e_dist_ff[j][F-j]) begin
            acc_in = e_acc_ff[j];
         end else if (e_acc_ff[j][32]) begin
            acc_in = {1'b0, C};
         end else begin
            acc_in = {1'b0, prod[63:32]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            e_valid_ff[j+1] <= 1'b0;
         end else if (adv) begin
            e_valid_ff[j+1] <= e_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            e_acc_ff[j+1]  <= acc_in;
            e_dist_ff[j+1] <= e_dist_ff[j];
            e_swap_ff[j+1] <= e_swap_ff[j];
         end
      end
   end

   // squaring: r = 1 - g^2, held below one
   logic [63:0] sq_prod;
   logic [31:0] sq_r;

   always_comb begin
      sq_prod = 64'(e_acc_ff[NEXP][31:0]) * 64'(e_acc_ff[NEXP][31:0]);
      if (e_acc_ff[NEXP][32]) begin
         sq_r = '0;
      end else if (sq_prod[63:32] == '0) begin
         sq_r = '1;
      end else begin
         sq_r = 32'(0) - sq_prod[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         s_valid_ff[0] <= e_valid_ff[NEXP];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_rem_ff[0]  <= '0;
         s_root_ff[0] <= '0;
         s_rad_ff[0]  <= sq_r;
         s_near_ff[0] <= e_acc_ff[NEXP];
         s_swap_ff[0] <= e_swap_ff[NEXP];
      end
   end

   // one root bit per stage; the low half of the radicand is zero
   for (genvar k = 0; k < NSQRT; k++) begin : g_sqrt
      logic [REM_W+1:0] rem2, test;
      logic             ge;
      logic [REM_W-1:0] rem_in;

      always_comb begin
         rem2   = {s_rem_ff[k], s_rad_ff[k][31:30]};
         test   = {(REM_W - 32)'(0), s_root_ff[k], 2'b01};
         ge     = (rem2 >= test);
         rem_in = ge ? REM_W'(rem2 - test) : REM_W'(rem2);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            s_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            s_valid_ff[k+1] <= s_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            s_rem_ff[k+1]  <= rem_in;
            s_root_ff[k+1] <= {s_root_ff[k][30:0], ge};
            s_rad_ff[k+1]  <= {s_rad_ff[k][29:0], 2'b00};
            s_near_ff[k+1] <= s_near_ff[k];
            s_swap_ff[k+1] <= s_swap_ff[k];
         end
      end
   end

   // round to nearest, ties up, then clamp to unity
   function automatic logic [F:0] to_gain(input logic [32:0] g);
      logic [33:0]  sum;
      logic [F+1:0] v;
      sum = {1'b0, g} + (34'd1 << (31 - F));
      v   = sum[33:32-F];
      if (v > (F+2)'(1) << F) begin
         return (F+1)'(1) << F;
      end
      return v[F:0];
   endfunction

   logic [F:0] near_q, far_q;

   always_comb begin
      near_q = to_gain(s_near_ff[NSQRT]);
      far_q  = to_gain({1'b0, s_root_ff[NSQRT]});
      out_left_in  = s_swap_ff[NSQRT] ? far_q  : near_q;
      out_right_in = s_swap_ff[NSQRT] ? near_q : far_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= s_valid_ff[NSQRT];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_left_ff  <= out_left_in;
         out_right_ff <= out_right_in;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_left_gain  = out_left_ff;
   assign rsp_right_gain = out_right_ff;

endmodule

>>> rtl/core/constant_power_pan_gains_core.sv
// ----------------------------------------------------------------------------
// constant_power_pan_gains_core
// Constant-power pan law: pan position in, left and right Q1.F gains out.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue write port: req_pan_position is taken on a clock edge
//   with req_push high and req_full low. Signed Q1.F, -1 is full left.
//   Results come from a queue read port: while rsp_empty is low the oldest
//   result sits on rsp_left_gain / rsp_right_gain (unsigned Q1.F, 2^F is
//   unity) and is removed on an edge with rsp_pop high.
//   Throughput is one item per cycle while results are popped.
//   The path from accept to rsp_empty falling runs through the input register,
//   the queue, the exp2 load register, the F+1 exp2 multiply stages, the squaring
//   register, the 32 square root stages (one bit per stage) and the output register.
//   When results are not popped the gain pipeline holds in place; a two-entry
//   queue and the input register then fill and req_full rises.
//   Reset (synchronous, active high) empties every stage; no items survive.
// ----------------------------------------------------------------------------
`include "constant_power_pan_gains_core_macros.svh"

module constant_power_pan_gains_core #(
   parameter int FRACTION_BITS = 15
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [FRACTION_BITS:0]   req_pan_position,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [FRACTION_BITS:0]   rsp_left_gain,
   output logic [FRACTION_BITS:0]   rsp_right_gain
);
   import cppg_pkg::*;

   localparam int QW = FRACTION_BITS + 2;
   localparam logic [FRACTION_BITS:0] GAIN_ONE =
      (FRACTION_BITS+1)'(1) << FRACTION_BITS;

   logic                   f_valid, f_ready, f_swap;
   logic [FRACTION_BITS:0] f_dist;
   logic                   q_valid, q_take;
   logic [QW-1:0]          q_data;

   cppg_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pan_position (req_pan_position),
      .item_valid       (f_valid),
      .item_ready       (f_ready),
      .item_dist        (f_dist),
      .item_swap        (f_swap)
   );

   cppg_queue #(.WIDTH(QW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  ({f_swap, f_dist}),
      .rd_valid (q_valid),
      .rd_take  (q_take),
      .rd_data  (q_data)
   );

   cppg_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (q_valid),
      .item_take      (q_take),
      .item_dist      (q_data[FRACTION_BITS:0]),
      .item_swap      (q_data[QW-1]),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_left_gain  (rsp_left_gain),
      .rsp_right_gain (rsp_right_gain)
   );

   `CPPG_ASSERT_NOW(a_gain_range, !rsp_empty, (rsp_left_gain <= GAIN_ONE) && (rsp_right_gain <= GAIN_ONE))
   `CPPG_ASSERT_NOW(a_full_needs_backlog, req_full, f_valid && q_valid)
   `CPPG_ASSERT_NEXT(a_result_kept, !rsp_empty && !rsp_pop, !rsp_empty)

endmodule
